/* rtl/qpms_pkg.sv */
// ----------------------------------------------------------------------------
// qpms_pkg: shared types and constants of the encoder position and speed block
// Field widths, register indexes, reset values and the item types that pass
// between the front end, the queue and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package qpms_pkg;

  localparam int unsigned RawW       = 20;
  localparam int unsigned AngW       = 24;
  localparam int unsigned IncW       = 21;
  localparam int unsigned SpdW       = 32;
  localparam int unsigned CprW       = 21;
  localparam int unsigned ScaleW     = 32;
  localparam int unsigned OmegaW     = 20;
  localparam int unsigned CountBits  = 20;
  localparam int unsigned WindowDef  = 32;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned AddrW      = 5;
  localparam int unsigned DataW      = 32;
  localparam int unsigned InDataW    = 24;
  localparam int unsigned OutDataW   = 136;

  localparam logic [2:0] REG_DIR    = 3'd0;
  localparam logic [2:0] REG_OFFSET = 3'd1;
  localparam logic [2:0] REG_CPR    = 3'd2;
  localparam logic [2:0] REG_ANGLE  = 3'd3;
  localparam logic [2:0] REG_SPEED  = 3'd4;
  localparam logic [2:0] REG_OMEGA  = 3'd5;

  localparam logic [CprW-1:0]   CprRst   = CprW'(4096);
  localparam logic [OmegaW-1:0] OmegaRst = OmegaW'(6863);

  typedef struct packed {
    logic            neg;
    logic [RawW-1:0] mag;
  } front_item_t;

  typedef struct packed {
    logic signed [SpdW-1:0] speed_rad;
    logic signed [SpdW-1:0] speed_rpm;
    logic signed [IncW-1:0] count_increment;
    logic [AngW-1:0]        elec_angle;
    logic [RawW-1:0]        abs_count;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_ACC,
    ST_RPM,
    ST_RND,
    ST_RAD,
    ST_OUT
  } back_state_e;

endpackage

`default_nettype wire

/* rtl/qpms_position_moving_average_speed.sv */
// Each accepted item passes the bit-serial revolution wrap (20 remainder steps)
// and then the multiply and rounding steps of the back end, which takes no new
// item until its result is loaded into the output register.
// A two-item queue lets the input side accept while the back end is busy.
// Reset (rst_ni low, asynchronous) clears the history, the increment ring's
// valid bits, the queue and the output, and loads the register reset values.
// ----------------------------------------------------------------------------
// qep_position_moving_average_speed: encoder position and speed top level
// Holds the configuration registers behind the APB port and connects the
// input stage, the queue and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module qep_position_moving_average_speed import qpms_pkg::*; #(
  parameter int unsigned Window = WindowDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output      logic                s_axis_tready,
  // [19:0] raw_count, [23:20] zero
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  output      logic                m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // [19:0] abs_count, [43:20] elec_angle, [64:44] count_increment,
  // [96:65] speed_rpm, [128:97] speed_rad, [135:129] zero
  output      logic [OutDataW-1:0] m_axis_tdata,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [AddrW-1:0]    paddr,
  input  wire logic [DataW-1:0]    pwdata,
  output      logic [DataW-1:0]    prdata,
  output      logic                pready
);

  localparam int unsigned PadW = OutDataW - $bits(result_t);

  logic              count_direction_q;
  logic [RawW-1:0]   position_offset_q;
  logic [CprW-1:0]   counts_per_rev_q;
  logic [ScaleW-1:0] angle_scale_q;
  logic [ScaleW-1:0] speed_scale_q;
  logic [OmegaW-1:0] omega_scale_q;
  logic              cfg_we;
  logic [2:0]        reg_idx;

  logic              push;
  logic              queue_full;
  logic              queue_valid;
  logic              pop;
  front_item_t       front_item;
  front_item_t       queue_item;
  result_t           result;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_direction_q <= 1'b0;
      position_offset_q <= '0;
      counts_per_rev_q  <= CprRst;
      angle_scale_q     <= '0;
      speed_scale_q     <= '0;
      omega_scale_q     <= OmegaRst;
    end else if (cfg_we) begin
      case (reg_idx)
        REG_DIR:    count_direction_q <= pwdata[0];
        REG_OFFSET: position_offset_q <= pwdata[RawW-1:0];
        REG_CPR:    counts_per_rev_q  <= pwdata[CprW-1:0];
        REG_ANGLE:  angle_scale_q     <= pwdata[ScaleW-1:0];
        REG_SPEED:  speed_scale_q     <= pwdata[ScaleW-1:0];
        REG_OMEGA:  omega_scale_q     <= pwdata[OmegaW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DIR:    prdata = DataW'(count_direction_q);
      REG_OFFSET: prdata = DataW'(position_offset_q);
      REG_CPR:    prdata = DataW'(counts_per_rev_q);
      REG_ANGLE:  prdata = DataW'(angle_scale_q);
      REG_SPEED:  prdata = DataW'(speed_scale_q);
      REG_OMEGA:  prdata = DataW'(omega_scale_q);
      default:    prdata = '0;
    endcase
  end

  qpms_front u_front (
    .s_axis_tvalid_i  (s_axis_tvalid),
    .s_axis_tready_o  (s_axis_tready),
    .raw_count_i      (s_axis_tdata[RawW-1:0]),
    .count_direction_i(count_direction_q),
    .position_offset_i(position_offset_q),
    .queue_full_i     (queue_full),
    .push_o           (push),
    .item_o           (front_item)
  );

  qpms_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (front_item),
    .full_o (queue_full),
    .pop_i  (pop),
    .valid_o(queue_valid),
    .item_o (queue_item)
  );

  qpms_back #(
    .Window(Window)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_valid_i    (queue_valid),
    .item_i          (queue_item),
    .pop_o           (pop),
    .counts_per_rev_i(counts_per_rev_q),
    .angle_scale_i   (angle_scale_q),
    .speed_scale_i   (speed_scale_q),
    .omega_scale_i   (omega_scale_q),
    .res_valid_o     (m_axis_tvalid),
    .res_ready_i     (m_axis_tready),
    .res_o           (result)
  );

  assign m_axis_tdata = {{PadW{1'b0}}, result};

endmodule

`default_nettype wire

/* rtl/qpms_front.sv */
// ----------------------------------------------------------------------------
// qpms_front: input stage
// Takes a raw position sample, removes the index offset, applies the count
// direction and splits the corrected count into sign and magnitude.
// ----------------------------------------------------------------------------
`default_nettype none

module qpms_front import qpms_pkg::*; (
  input  wire logic               s_axis_tvalid_i,
  output      logic               s_axis_tready_o,
  input  wire logic [RawW-1:0]    raw_count_i,
  input  wire logic               count_direction_i,
  input  wire logic [RawW-1:0]    position_offset_i,
  input  wire logic               queue_full_i,
  output      logic               push_o,
  output      front_item_t        item_o
);

  logic signed [RawW:0] diff;
  logic signed [RawW:0] diff_abs;

  always_comb begin
    diff     = $signed({1'b0, raw_count_i}) - $signed({1'b0, position_offset_i});
    diff_abs = diff[RawW] ? -diff : diff;
    item_o.mag = diff_abs[RawW-1:0];
    item_o.neg = diff[RawW] ^ count_direction_i;
  end

  assign s_axis_tready_o = !queue_full_i;
  assign push_o          = s_axis_tvalid_i && !queue_full_i;

endmodule

`default_nettype wire

/* rtl/qpms_fifo.sv */
// ----------------------------------------------------------------------------
// qpms_fifo: short queue between front and back end
// Holds classified items so that the input side keeps accepting while the
// back end works.
// ----------------------------------------------------------------------------
`default_nettype none

module qpms_fifo import qpms_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire front_item_t item_i,
  output      logic        full_o,
  input  wire logic        pop_i,
  output      logic        valid_o,
  output      front_item_t item_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QueueDepth - 1);

  front_item_t     mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (count_q == CntW'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/qpms_mod.sv */
// ----------------------------------------------------------------------------
// qpms_mod: revolution wrap unit
// Restoring remainder, one bit per cycle, of the count magnitude by the
// counts per revolution, folded into 0 .. cpr-1 for negative counts.
// ----------------------------------------------------------------------------
`default_nettype none

module qpms_mod import qpms_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire front_item_t     op_i,
  input  wire logic [CprW-1:0] cpr_i,
  output      logic            done_o,
  output      logic [RawW-1:0] res_o
);

  localparam int unsigned CntW = $clog2(RawW);
  localparam logic [CntW-1:0] CntLast = CntW'(RawW - 1);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [RawW-1:0] dvd_q;
  logic [RawW-1:0] rem_q;
  logic            neg_q;
  logic [RawW:0]   shifted;
  logic [RawW:0]   trial;
  logic [RawW-1:0] rem_next;
  logic [CprW-1:0] fold;

  always_comb begin
    shifted  = {rem_q, dvd_q[RawW-1]};
    trial    = shifted - cpr_i;
    rem_next = (shifted >= cpr_i) ? trial[RawW-1:0] : shifted[RawW-1:0];
    fold     = cpr_i - CprW'(rem_q);
    res_o    = (neg_q && (rem_q != '0)) ? fold[RawW-1:0] : rem_q;
  end

  assign done_o = done_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= op_i.mag;
      neg_q <= op_i.neg;
    end else if (busy_q) begin
      rem_q <= rem_next;
      dvd_q <= {dvd_q[RawW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/qpms_back.sv */
// ----------------------------------------------------------------------------
// qpms_back: position and speed back end
// Wraps the count, unwraps the increment, keeps the increment ring with its
// running sum, scales the sum to rpm and the rpm to rad/s with rounding and
// saturation, and scales the wrapped count to a saturated electrical angle.
// ----------------------------------------------------------------------------
`default_nettype none

module qpms_back import qpms_pkg::*; #(
  parameter int unsigned Window = WindowDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              item_valid_i,
  input  wire front_item_t       item_i,
  output      logic              pop_o,
  input  wire logic [CprW-1:0]   counts_per_rev_i,
  input  wire logic [ScaleW-1:0] angle_scale_i,
  input  wire logic [ScaleW-1:0] speed_scale_i,
  input  wire logic [OmegaW-1:0] omega_scale_i,
  output      logic              res_valid_o,
  input  wire logic              res_ready_i,
  output      result_t           res_o
);

  localparam int unsigned CurW     = (Window > 1) ? $clog2(Window) : 1;
  localparam int unsigned TotW     = IncW + $clog2(Window);
  localparam int unsigned AngProdW = RawW + ScaleW;
  localparam int unsigned RpmProdW = TotW + ScaleW;
  localparam int unsigned RpmPW    = RpmProdW + 1 - 16;
  localparam int unsigned RadProdW = SpdW + OmegaW;
  localparam int unsigned RadPW    = RadProdW + 1 - 16;
  localparam logic [CurW-1:0]     CurLast   = CurW'(Window - 1);
  localparam logic [CprW-1:0]     CprMax    = CprW'(1) << CountBits;
  localparam logic [AngProdW-1:0] AngLim    = AngProdW'(24'hFFFFFF);
  localparam logic [RpmPW-1:0]    RpmNegLim = RpmPW'(33'h080000000);
  localparam logic [RpmPW-1:0]    RpmPosLim = RpmPW'(33'h07FFFFFFF);
  localparam logic [RadPW-1:0]    RadNegLim = RadPW'(33'h080000000);
  localparam logic [RadPW-1:0]    RadPosLim = RadPW'(33'h07FFFFFFF);

  back_state_e state_q;
  back_state_e state_d;

  logic                   mod_start;
  logic                   mod_done;
  logic [RawW-1:0]        mod_res;
  logic [CprW-1:0]        cpr_eff;
  logic                   load_out;

  logic signed [IncW:0]   diff;
  logic signed [IncW+1:0] twice;
  logic signed [IncW+1:0] cpr_s;
  logic signed [IncW:0]   adj;

  logic [RawW-1:0]        prev_q;
  logic [RawW-1:0]        abs_q;
  logic signed [IncW-1:0] inc_q;
  logic signed [TotW-1:0] total_q;
  logic [CurW-1:0]        cursor_q;
  logic [Window-1:0]      vld_q;
  logic signed [IncW-1:0] ring_mem [Window];
  logic signed [IncW-1:0] rd_q;
  logic signed [IncW-1:0] old_inc;

  logic [AngProdW-1:0]    angle_prod_q;
  logic [TotW-1:0]        tot_mag;
  logic                   tot_neg_q;
  logic [RpmProdW-1:0]    rpm_prod_q;
  logic [RpmProdW:0]      rpm_rnd;
  logic [RpmPW-1:0]       rpm_p;
  logic signed [SpdW-1:0] rpm_sat;
  logic signed [SpdW-1:0] rpm_q;
  logic [SpdW-1:0]        rpm_mag;
  logic                   rad_neg_q;
  logic [RadProdW-1:0]    rad_prod_q;
  logic [RadProdW:0]      rad_rnd;
  logic [RadPW-1:0]       rad_p;
  logic signed [SpdW-1:0] rad_sat;
  logic [AngW-1:0]        angle_sat;

  logic                   out_valid_q;
  result_t                out_q;

  always_comb begin
    if (counts_per_rev_i < CprW'(2)) begin
      cpr_eff = CprW'(2);
    end else if (counts_per_rev_i > CprMax) begin
      cpr_eff = CprMax;
    end else begin
      cpr_eff = counts_per_rev_i;
    end
  end

  qpms_mod u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mod_start),
    .op_i   (item_i),
    .cpr_i  (cpr_eff),
    .done_o (mod_done),
    .res_o  (mod_res)
  );

  always_comb begin
    diff  = $signed({2'b00, mod_res}) - $signed({2'b00, prev_q});
    twice = {diff, 1'b0};
    cpr_s = $signed({2'b00, cpr_eff});
    if (twice < -cpr_s) begin
      adj = diff + $signed({1'b0, cpr_eff});
    end else if (twice > cpr_s) begin
      adj = diff - $signed({1'b0, cpr_eff});
    end else begin
      adj = diff;
    end
  end

  always_comb begin
    old_inc = vld_q[cursor_q] ? rd_q : '0;
    tot_mag = total_q[TotW-1] ? TotW'(-total_q) : TotW'(total_q);
    rpm_mag = rpm_q[SpdW-1] ? SpdW'(-rpm_q) : SpdW'(rpm_q);

    rpm_rnd = {1'b0, rpm_prod_q} + (RpmProdW+1)'(32768);
    rpm_p   = rpm_rnd[RpmProdW:16];
    if (tot_neg_q) begin
      rpm_sat = (rpm_p > RpmNegLim) ? $signed(32'h80000000) : -$signed(rpm_p[SpdW-1:0]);
    end else begin
      rpm_sat = (rpm_p > RpmPosLim) ? $signed(32'h7FFFFFFF) : $signed(rpm_p[SpdW-1:0]);
    end

    rad_rnd = {1'b0, rad_prod_q} + (RadProdW+1)'(32768);
    rad_p   = rad_rnd[RadProdW:16];
    if (rad_neg_q) begin
      rad_sat = (rad_p > RadNegLim) ? $signed(32'h80000000) : -$signed(rad_p[SpdW-1:0]);
    end else begin
      rad_sat = (rad_p > RadPosLim) ? $signed(32'h7FFFFFFF) : $signed(rad_p[SpdW-1:0]);
    end

    angle_sat = (angle_prod_q > AngLim) ? '1 : angle_prod_q[AngW-1:0];
  end

  always_comb begin
    state_d   = state_q;
    pop_o     = 1'b0;
    mod_start = 1'b0;
    load_out  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          pop_o     = 1'b1;
          mod_start = 1'b1;
          state_d   = ST_MOD;
        end
      end
      ST_MOD: begin
        if (mod_done) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        state_d = ST_RPM;
      end
      ST_RPM: begin
        state_d = ST_RND;
      end
      ST_RND: begin
        state_d = ST_RAD;
      end
      ST_RAD: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || res_ready_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= ring_mem[cursor_q];
    if (state_q == ST_ACC) begin
      ring_mem[cursor_q] <= inc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      total_q     <= '0;
      cursor_q    <= '0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == ST_MOD) && mod_done) begin
        prev_q <= mod_res;
      end
      if (state_q == ST_ACC) begin
        total_q         <= total_q - TotW'(old_inc) + TotW'(inc_q);
        vld_q[cursor_q] <= 1'b1;
        cursor_q        <= (cursor_q == CurLast) ? '0 : cursor_q + 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_MOD: begin
        if (mod_done) begin
          abs_q <= mod_res;
          inc_q <= adj[IncW-1:0];
        end
      end
      ST_ACC: begin
        angle_prod_q <= AngProdW'(abs_q) * AngProdW'(angle_scale_i);
      end
      ST_RPM: begin
        tot_neg_q  <= total_q[TotW-1];
        rpm_prod_q <= RpmProdW'(tot_mag) * RpmProdW'(speed_scale_i);
      end
      ST_RND: begin
        rpm_q <= rpm_sat;
      end
      ST_RAD: begin
        rad_neg_q  <= rpm_q[SpdW-1];
        rad_prod_q <= RadProdW'(rpm_mag) * RadProdW'(omega_scale_i);
      end
      ST_OUT: begin
        if (load_out) begin
          out_q.abs_count       <= abs_q;
          out_q.elec_angle      <= angle_sat;
          out_q.count_increment <= inc_q;
          out_q.speed_rpm       <= rpm_q;
          out_q.speed_rad       <= rad_sat;
        end
      end
      default: begin
      end
    endcase
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

`default_nettype wire
